FILE: rtl/rle_mask_clipped_span_blit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the run-length mask span blitter
// Concurrent assertion shorthands; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef RLE_MASK_CLIPPED_SPAN_BLIT_MACROS_SVH
`define RLE_MASK_CLIPPED_SPAN_BLIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RMCSB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RMCSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RMCSB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`define RMCSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: rtl/rmcsb_pkg.sv
// ----------------------------------------------------------------------------
// rmcsb_pkg
// Widths, codes and shared types of the run-length mask span blitter.
// ----------------------------------------------------------------------------
package rmcsb_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int ORG_W      = 12;
  localparam int OFS_W      = 22;
  localparam int LEN_W      = 8;
  localparam int CLIP_W     = 11;
  localparam int PITCH_W    = 12;

  // Internal widths
  localparam int EDGE_W     = 13;  // signed left edge, origin plus hot x
  localparam int TOP_W      = 12;  // unsigned top edge, clamped origin plus hot y
  localparam int CMP_W      = 14;  // signed compare width for the clip test
  localparam int MARG_W     = 12;
  localparam int COL_W      = 17;  // column position over up to 256 runs
  localparam int SPN_W      = 18;  // signed span bound width
  localparam int BLK_W      = 9;
  localparam int ROW_W      = 8;
  localparam int HDR_W      = 2;
  localparam int PH_W       = 3;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam int FRAME_DIM_DEF = 2048;

  // Parse phases
  localparam logic [PH_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PH_W-1:0] PH_HEADER = 3'd1;
  localparam logic [PH_W-1:0] PH_COUNT  = 3'd2;
  localparam logic [PH_W-1:0] PH_SKIP   = 3'd3;
  localparam logic [PH_W-1:0] PH_COPY   = 3'd4;

  // Header byte positions
  localparam logic [HDR_W-1:0] HDR_WIDTH  = 2'd0;
  localparam logic [HDR_W-1:0] HDR_HEIGHT = 2'd1;
  localparam logic [HDR_W-1:0] HDR_HOT_X  = 2'd2;
  localparam logic [HDR_W-1:0] HDR_HOT_Y  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PITCH = 3'd4;

  // Register reset values
  localparam logic [CLIP_W-1:0]  CLIP_LEFT_RST   = 11'd0;
  localparam logic [CLIP_W-1:0]  CLIP_TOP_RST    = 11'd0;
  localparam logic [CLIP_W-1:0]  CLIP_RIGHT_RST  = 11'd639;
  localparam logic [CLIP_W-1:0]  CLIP_BOTTOM_RST = 11'd479;
  localparam logic [PITCH_W-1:0] FRAME_PITCH_RST = 12'd640;

  typedef struct packed {
    logic [CLIP_W-1:0]  clip_left;
    logic [CLIP_W-1:0]  clip_top;
    logic [CLIP_W-1:0]  clip_right;
    logic [CLIP_W-1:0]  clip_bottom;
    logic [PITCH_W-1:0] frame_pitch;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]       mask_byte;
    logic                    mask_start;
    logic signed [ORG_W-1:0] origin_x;
    logic signed [ORG_W-1:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic              span_valid;
    logic [OFS_W-1:0]  span_offset;
    logic [LEN_W-1:0]  span_length;
    logic              mask_done;
    logic              mask_rejected;
  } res_t;

endpackage

FILE: rtl/rmcsb_ifs.sv
// ----------------------------------------------------------------------------
// rmcsb channel interfaces
// Valid/ready channels for mask byte requests and span results.
// ----------------------------------------------------------------------------
interface rmcsb_in_if;
  import rmcsb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [BYTE_W-1:0]       mask_byte;
  logic                    mask_start;
  logic signed [ORG_W-1:0] origin_x;
  logic signed [ORG_W-1:0] origin_y;

  modport source (output valid, output mask_byte, output mask_start,
                  output origin_x, output origin_y, input ready);
  modport sink   (input valid, input mask_byte, input mask_start,
                  input origin_x, input origin_y, output ready);
endinterface

interface rmcsb_out_if;
  import rmcsb_pkg::*;

  logic             valid;
  logic             ready;
  logic             span_valid;
  logic [OFS_W-1:0] span_offset;
  logic [LEN_W-1:0] span_length;
  logic             mask_done;
  logic             mask_rejected;

  modport source (output valid, output span_valid, output span_offset,
                  output span_length, output mask_done, output mask_rejected,
                  input ready);
  modport sink   (input valid, input span_valid, input span_offset,
                  input span_length, input mask_done, input mask_rejected,
                  output ready);
endinterface

FILE: rtl/rmcsb_cfg_regs.sv
// ----------------------------------------------------------------------------
// rmcsb_cfg_regs
// APB-style register file: clip window and frame pitch.
// ----------------------------------------------------------------------------
module rmcsb_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rmcsb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rmcsb_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rmcsb_pkg::CFG_DATA_W-1:0]   prdata,
  output rmcsb_pkg::cfg_t                    cfg
);
  import rmcsb_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_CLIP_LEFT:   cfg_nxt.clip_left   = pwdata[CLIP_W-1:0];
        REG_CLIP_TOP:    cfg_nxt.clip_top    = pwdata[CLIP_W-1:0];
        REG_CLIP_RIGHT:  cfg_nxt.clip_right  = pwdata[CLIP_W-1:0];
        REG_CLIP_BOTTOM: cfg_nxt.clip_bottom = pwdata[CLIP_W-1:0];
        REG_FRAME_PITCH: cfg_nxt.frame_pitch = pwdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CLIP_LEFT:   prdata = CFG_DATA_W'(cfg_r.clip_left);
      REG_CLIP_TOP:    prdata = CFG_DATA_W'(cfg_r.clip_top);
      REG_CLIP_RIGHT:  prdata = CFG_DATA_W'(cfg_r.clip_right);
      REG_CLIP_BOTTOM: prdata = CFG_DATA_W'(cfg_r.clip_bottom);
      REG_FRAME_PITCH: prdata = CFG_DATA_W'(cfg_r.frame_pitch);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left   <= CLIP_LEFT_RST;
      cfg_r.clip_top    <= CLIP_TOP_RST;
      cfg_r.clip_right  <= CLIP_RIGHT_RST;
      cfg_r.clip_bottom <= CLIP_BOTTOM_RST;
      cfg_r.frame_pitch <= FRAME_PITCH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/rmcsb_parser.sv
// ----------------------------------------------------------------------------
// rmcsb_parser
// Mask byte parser: header placement, clip test, row walk and span clipping.
// ----------------------------------------------------------------------------
`include "rle_mask_clipped_span_blit_macros.svh"

module rmcsb_parser #(
  parameter int FRAME_DIM = rmcsb_pkg::FRAME_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  rmcsb_pkg::in_item_t in_item,
  input  rmcsb_pkg::cfg_t     cfg,
  output rmcsb_pkg::res_t     res
);
  import rmcsb_pkg::*;

  localparam int LINE_W = $clog2(FRAME_DIM);

  typedef struct packed {
    logic [MARG_W-1:0] left;
    logic [MARG_W-1:0] right;
    logic [MARG_W-1:0] top;
    logic [MARG_W-1:0] bottom;
  } margins_t;

  logic [PH_W-1:0]          phase_r, phase_nxt, phase_eff;
  logic [HDR_W-1:0]         hidx_r, hidx_nxt, hidx_eff;
  logic [BYTE_W-1:0]        width_r, width_nxt, height_r, height_nxt;
  logic signed [EDGE_W-1:0] left_r, left_nxt, left_eff;
  logic [TOP_W-1:0]         top_r, top_nxt, top_eff;
  logic [ROW_W-1:0]         row_r, row_nxt;
  logic [BLK_W-1:0]         blk_r, blk_nxt, blk_dec;
  logic [COL_W-1:0]         col_r, col_nxt, col_sum;
  logic [OFS_W-1:0]         base_r, base_nxt, base_init, base_adv;
  margins_t                 marg_r, marg_nxt, marg_calc;

  logic [BYTE_W-1:0]        b;

  // Header finish
  logic [TOP_W-1:0]         y0;
  logic signed [EDGE_W-1:0] x0;
  logic signed [CMP_W-1:0]  x0c, x1c, y0c, y1c, clc, ctc, crc, cbc;
  logic                     partial, outside;
  logic                     line_sat;
  logic [LINE_W-1:0]        line;
  logic [LINE_W+PITCH_W-1:0] prod;

  // Copy span
  logic [COL_W-1:0]         lo;
  logic signed [SPN_W-1:0]  lo_s, hi_raw, hi_s, lim_s;
  logic signed [CMP_W-1:0]  row_c, vis_lim;
  logic                     row_vis, span_hit;

  // Row end
  logic [ROW_W:0]           row_inc;
  logic                     last_row;

  assign b = in_item.mask_byte;

  // A start byte restarts the header whatever the parser was doing.
  always_comb begin
    if (in_item.mask_start) begin
      phase_eff = PH_HEADER;
      hidx_eff  = HDR_WIDTH;
      left_eff  = {in_item.origin_x[ORG_W-1], in_item.origin_x};
      top_eff   = in_item.origin_y[ORG_W-1] ? '0 : TOP_W'(in_item.origin_y);
    end else begin
      phase_eff = phase_r;
      hidx_eff  = hidx_r;
      left_eff  = left_r;
      top_eff   = top_r;
    end
  end

  // Placement and clip test on the hot y byte
  assign y0  = top_eff + TOP_W'(b);
  assign x0  = left_eff;
  assign x0c = {{(CMP_W-EDGE_W){x0[EDGE_W-1]}}, x0};
  assign x1c = x0c + CMP_W'(width_r) - CMP_W'(1);
  assign y0c = CMP_W'(y0);
  assign y1c = y0c + CMP_W'(height_r) - CMP_W'(1);
  assign clc = CMP_W'(cfg.clip_left);
  assign ctc = CMP_W'(cfg.clip_top);
  assign crc = CMP_W'(cfg.clip_right);
  assign cbc = CMP_W'(cfg.clip_bottom);

  assign partial = (x0c < clc) || (y0c < ctc) || (x1c > crc) || (y1c > cbc);
  assign outside = (x0c > crc) || (y0c > cbc) || (x1c < clc) || (y1c < ctc);

  assign marg_calc.top    = (y0c < ctc) ? MARG_W'(ctc - y0c) : '0;
  assign marg_calc.bottom = (y1c > cbc) ? MARG_W'(y1c - cbc) : '0;
  assign marg_calc.left   = (x0c < clc) ? MARG_W'(clc - x0c) : '0;
  assign marg_calc.right  = (x1c > crc) ? MARG_W'(x1c - crc) : '0;

  // Saturate the first line index to the line table range.
  assign line_sat  = y0 > TOP_W'(FRAME_DIM - 1);
  assign line      = line_sat ? LINE_W'(FRAME_DIM - 1) : y0[LINE_W-1:0];
  assign prod      = line * cfg.frame_pitch;
  assign base_init = OFS_W'(prod) + {{(OFS_W-EDGE_W){x0[EDGE_W-1]}}, x0};

  // Visible part of a copy run
  assign lo      = (col_r > COL_W'(marg_r.left)) ? col_r : COL_W'(marg_r.left);
  assign lo_s    = SPN_W'(lo);
  assign lim_s   = SPN_W'(width_r) - SPN_W'(marg_r.right);
  assign hi_raw  = SPN_W'(col_r) + SPN_W'(b);
  assign hi_s    = (hi_raw > lim_s) ? lim_s : hi_raw;
  assign row_c   = CMP_W'(row_r);
  assign vis_lim = CMP_W'(height_r) - CMP_W'(marg_r.bottom);
  assign row_vis = (MARG_W'(row_r) >= marg_r.top) && (row_c < vis_lim);
  assign span_hit = row_vis && (hi_s > lo_s);

  // Running position; a row end covers every run of the row.
  assign col_sum  = col_r + COL_W'(b);
  assign blk_dec  = blk_r - 1'b1;
  assign base_adv = base_r + OFS_W'(col_sum) + OFS_W'(cfg.frame_pitch) - OFS_W'(width_r);
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign last_row = row_inc >= {1'b0, height_r};

  always_comb begin
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    left_nxt   = left_eff;
    top_nxt    = top_eff;
    row_nxt    = row_r;
    blk_nxt    = blk_r;
    col_nxt    = col_r;
    base_nxt   = base_r;
    marg_nxt   = marg_r;
    res        = '0;

    case (phase_eff)
      PH_HEADER: begin
        phase_nxt = PH_HEADER;
        hidx_nxt  = hidx_eff + 1'b1;
        case (hidx_eff)
          HDR_WIDTH:  width_nxt  = b;
          HDR_HEIGHT: height_nxt = b;
          HDR_HOT_X:  left_nxt   = left_eff + EDGE_W'(b);
          HDR_HOT_Y: begin
            top_nxt = y0;
            if (partial && outside) begin
              phase_nxt         = PH_IDLE;
              res.mask_done     = 1'b1;
              res.mask_rejected = 1'b1;
            end else begin
              marg_nxt = marg_calc;
              base_nxt = base_init;
              row_nxt  = '0;
              col_nxt  = '0;
              if (height_r == '0) begin
                phase_nxt     = PH_IDLE;
                res.mask_done = 1'b1;
              end else begin
                phase_nxt = PH_COUNT;
              end
            end
          end
          default: ;
        endcase
      end
      PH_COUNT: begin
        blk_nxt   = (b == '0) ? BLK_W'(256) : BLK_W'(b);
        col_nxt   = '0;
        phase_nxt = PH_SKIP;
      end
      PH_SKIP, PH_COPY: begin
        if (phase_eff == PH_COPY && span_hit) begin
          res.span_valid  = 1'b1;
          res.span_offset = base_r + OFS_W'(lo);
          res.span_length = LEN_W'(hi_s - lo_s);
        end
        blk_nxt = blk_dec;
        if (blk_dec == '0) begin
          base_nxt = base_adv;
          row_nxt  = row_inc[ROW_W-1:0];
          col_nxt  = '0;
          if (last_row) begin
            phase_nxt     = PH_IDLE;
            res.mask_done = 1'b1;
          end else begin
            phase_nxt = PH_COUNT;
          end
        end else begin
          col_nxt   = col_sum;
          phase_nxt = (phase_eff == PH_SKIP) ? PH_COPY : PH_SKIP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hidx_r  <= HDR_WIDTH;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      row_r    <= row_nxt;
      blk_r    <= blk_nxt;
      col_r    <= col_nxt;
      base_r   <= base_nxt;
      marg_r   <= marg_nxt;
    end
  end

  `RMCSB_ASSERT_IMPL(a_span_in_copy, clk, rst_n, fire && res.span_valid, phase_r == PH_COPY && !in_item.mask_start, "span issued outside a copy run")
  `RMCSB_ASSERT_IMPL(a_runs_pending, clk, rst_n, phase_r == PH_SKIP || phase_r == PH_COPY, blk_r != '0, "run phase with no blocks left")
  `RMCSB_ASSERT_IMPL(a_hidx_rest, clk, rst_n, phase_r != PH_HEADER, hidx_r == HDR_WIDTH, "header index not at rest outside header")
  `RMCSB_ASSERT_NEXT(a_reject_idle, clk, rst_n, fire && res.mask_rejected, phase_r == PH_IDLE && hidx_r == HDR_WIDTH, "rejected mask left parser busy")

endmodule

FILE: rtl/rmcsb_out_stage.sv
// ----------------------------------------------------------------------------
// rmcsb_out_stage
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module rmcsb_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  rmcsb_pkg::res_t res,
  output logic            load_ok,
  rmcsb_out_if.source     out_chan
);
  import rmcsb_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  // Take a new result when empty or when the held one leaves this cycle.
  assign load_ok = !valid_r || out_chan.ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid         = valid_r;
  assign out_chan.span_valid    = res_r.span_valid;
  assign out_chan.span_offset   = res_r.span_offset;
  assign out_chan.span_length   = res_r.span_length;
  assign out_chan.mask_done     = res_r.mask_done;
  assign out_chan.mask_rejected = res_r.mask_rejected;

endmodule

FILE: rtl/rle_mask_clipped_span_blit.sv
// ----------------------------------------------------------------------------
// rle_mask_clipped_span_blit
// Run-length mask span generator with clip-window rejection and clipping.
// ----------------------------------------------------------------------------
// Feed the mask one byte per request: width, height, hot x, hot y (the first
// with mask_start set and origin_x/origin_y valid), then per row a block count
// (zero means 256) and alternating skip and copy run bytes. Every request
// yields exactly one result, in the cycle after it is accepted: a copy run that
// is partly or fully inside the clip window gives span_valid with the frame
// offset and length of its visible part, the byte that ends the mask gives
// mask_done, and a mask wholly outside the window ends on its last header
// byte with mask_done and mask_rejected. A byte arriving with no mask in
// progress gives an all-zero result. The block takes one request every cycle:
// all work for a byte is done by the parser between its state registers and
// the result register, and in_chan.ready drops only while a held result is
// not taken. The longest path is the header finish, one 11x12 multiply of the
// first line index by frame_pitch plus an add of the left edge. Write the
// registers (clip_left, clip_top, clip_right, clip_bottom, frame_pitch at
// byte addresses 0, 4, 8, 12, 16) only while no mask request is in flight.
// ----------------------------------------------------------------------------
module rle_mask_clipped_span_blit #(
  parameter int FRAME_DIM = rmcsb_pkg::FRAME_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rmcsb_in_if.sink                         in_chan,
  rmcsb_out_if.source                      out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rmcsb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rmcsb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rmcsb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import rmcsb_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  res_t     res;
  logic     in_fire;
  logic     load_ok;

  // Register writes complete in the access cycle; never stall the bus.
  assign pready = 1'b1;

  rmcsb_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Accept a mask byte whenever the result register can take its result.
  assign in_chan.ready = load_ok;
  assign in_fire       = in_chan.valid && load_ok;

  assign in_item.mask_byte  = in_chan.mask_byte;
  assign in_item.mask_start = in_chan.mask_start;
  assign in_item.origin_x   = in_chan.origin_x;
  assign in_item.origin_y   = in_chan.origin_y;

  // Parse, place, clip and advance the row pointer in one pass per byte.
  rmcsb_parser #(
    .FRAME_DIM (FRAME_DIM)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .in_item (in_item),
    .cfg     (cfg),
    .res     (res)
  );

  // Hold the result until the sink takes it.
  rmcsb_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire),
    .res      (res),
    .load_ok  (load_ok),
    .out_chan (out_chan)
  );

endmodule

FILE: tb/sv/rle_mask_clipped_span_blit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_mask_clipped_span_blit_test
// Streams run-length masks into the span blitter under several clip windows
// and frame pitches. Random stalls fall on both channels. An in-bench tracker
// predicts every span, done and reject result and checks it field by field.
// ----------------------------------------------------------------------------
module rle_mask_clipped_span_blit_test;
  import rmcsb_pkg::*;

  localparam int FRAME_DIM   = FRAME_DIM_DEF;
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 400000;

  // --------------------------------------------------------------------------
  // Span tracker: mirrors the parser state and the clip registers, predicts
  // one result per accepted mask byte and checks results in order.
  // --------------------------------------------------------------------------
  class span_tracker;
    int clip_l, clip_t, clip_r, clip_b, pitch;
    logic [PH_W-1:0]  phase;
    logic [HDR_W-1:0] hdr_pos;
    int mask_w, mask_h, left_x, top_y, col, row, blocks_left;
    int marg_l, marg_r, marg_t, marg_b;
    logic [OFS_W-1:0] line_base;
    res_t pend;
    res_t expected_spans[$];
    int mismatches, spans_seen, masks_done, masks_rejected;

    function new();
      clip_l = CLIP_LEFT_RST;
      clip_t = CLIP_TOP_RST;
      clip_r = CLIP_RIGHT_RST;
      clip_b = CLIP_BOTTOM_RST;
      pitch = FRAME_PITCH_RST;
      phase = PH_IDLE;
      hdr_pos = HDR_WIDTH;
      {mask_w, mask_h, left_x, top_y, col, row, blocks_left} = '0;
      {marg_l, marg_r, marg_t, marg_b} = '0;
      line_base = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
      case (idx)
        REG_CLIP_LEFT:   clip_l = value & 'h7FF;
        REG_CLIP_TOP:    clip_t = value & 'h7FF;
        REG_CLIP_RIGHT:  clip_r = value & 'h7FF;
        REG_CLIP_BOTTOM: clip_b = value & 'h7FF;
        REG_FRAME_PITCH: pitch = value & 'hFFF;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_spans.size();
    endfunction

    // Step the line pointer over the finished row; end the mask after the
    // last row.
    function void close_row(int extra);
      line_base = line_base + col + extra + pitch - mask_w;
      row++;
      col = 0;
      if (row >= mask_h) begin
        phase = PH_IDLE;
        pend.mask_done = 1'b1;
      end else begin
        phase = PH_COUNT;
      end
    endfunction

    function void note_request(in_item_t req);
      int b, oy, x0, y0, x1, y1, line, lo, hi, lim;
      bit row_vis;
      pend = '0;
      b = req.mask_byte;
      // A start byte abandons whatever mask is in progress.
      if (req.mask_start) begin
        phase = PH_HEADER;
        hdr_pos = HDR_WIDTH;
        left_x = $signed(req.origin_x);
        oy = $signed(req.origin_y);
        top_y = (oy < 0) ? 0 : oy;
      end
      case (phase)
        PH_HEADER: begin
          case (hdr_pos)
            HDR_WIDTH:  mask_w = b;
            HDR_HEIGHT: mask_h = b;
            HDR_HOT_X:  left_x += b;
            default: begin
              top_y += b;
              x0 = left_x;
              y0 = top_y;
              x1 = x0 + mask_w - 1;
              y1 = y0 + mask_h - 1;
              {marg_l, marg_r, marg_t, marg_b} = '0;
              if (x0 < clip_l || y0 < clip_t || x1 > clip_r || y1 > clip_b) begin
                if (x0 > clip_r || y0 > clip_b || x1 < clip_l || y1 < clip_t) begin
                  phase = PH_IDLE;
                  pend.mask_done = 1'b1;
                  pend.mask_rejected = 1'b1;
                end else begin
                  if (y0 < clip_t) marg_t = clip_t - y0;
                  if (y1 > clip_b) marg_b = y1 - clip_b;
                  if (x0 < clip_l) marg_l = clip_l - x0;
                  if (x1 > clip_r) marg_r = x1 - clip_r;
                end
              end
              if (!pend.mask_rejected) begin
                line = (y0 > FRAME_DIM - 1) ? FRAME_DIM - 1 : y0;
                line_base = line * pitch + x0;
                row = 0;
                col = 0;
                if (mask_h == 0) begin
                  phase = PH_IDLE;
                  pend.mask_done = 1'b1;
                end else begin
                  phase = PH_COUNT;
                end
              end
            end
          endcase
          hdr_pos = hdr_pos + 1'b1;
        end
        PH_COUNT: begin
          blocks_left = (b == 0) ? 256 : b;
          col = 0;
          phase = PH_SKIP;
        end
        PH_SKIP: begin
          blocks_left--;
          if (blocks_left == 0) begin
            close_row(b);
          end else begin
            col += b;
            phase = PH_COPY;
          end
        end
        PH_COPY: begin
          lo = (col > marg_l) ? col : marg_l;
          lim = mask_w - marg_r;
          hi = col + b;
          row_vis = row >= marg_t && row < mask_h - marg_b;
          if (hi > lim) hi = lim;
          if (row_vis && hi > lo) begin
            pend.span_valid = 1'b1;
            pend.span_offset = line_base + lo;
            pend.span_length = hi - lo;
          end
          col += b;
          blocks_left--;
          if (blocks_left == 0) close_row(0);
          else phase = PH_SKIP;
        end
        default: ;
      endcase
      expected_spans.push_back(pend);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_spans.size() == 0) begin
        $error("result with nothing pending: %h", got);
        mismatches++;
        return;
      end
      want = expected_spans.pop_front();
      compare("span_valid", want.span_valid, got.span_valid);
      compare("span_offset", want.span_offset, got.span_offset);
      compare("span_length", want.span_length, got.span_length);
      compare("mask_done", want.mask_done, got.mask_done);
      compare("mask_rejected", want.mask_rejected, got.mask_rejected);
      spans_seen += got.span_valid;
      masks_done += got.mask_done;
      masks_rejected += got.mask_rejected;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  always #2 clk = ~clk;

  rmcsb_in_if  in_if ();
  rmcsb_out_if out_if ();

  rle_mask_clipped_span_blit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  span_tracker spans;
  int  cycle_count = 0;
  int  req_total = 0;
  int  noise_reqs = 0;
  int  windows = 1;
  bit  hold_req = 1'b0;  // ask the result side for one long hold-off
  bit  burst = 1'b0;     // sender offers back to back
  bit  quiet = 1'b0;     // no idling on either side

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check every result taken at a clock edge.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      spans.check_result({out_if.span_valid, out_if.span_offset, out_if.span_length,
                          out_if.mask_done, out_if.mask_rejected});
  end

  // Result side: take results in random runs, stall in bursts of random length,
  // and serve one long hold-off on request so the block backs up.
  initial begin : result_sink
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic int rnd_org();
    return int'($urandom_range(3071)) - 1024;
  endfunction

  // Pick an origin that puts a span of the given size inside, across the low
  // edge, across the high edge of [lo, hi], or anywhere at all.
  function automatic int place(int lo, int hi, int size, int hot);
    int pos, org;
    case ($urandom_range(3))
      0: pos = lo + int'($urandom_range((hi - lo - size + 1 > 0) ? hi - lo - size + 1 : 0));
      1: pos = lo - int'($urandom_range(size));
      2: pos = hi - int'($urandom_range(size));
      default: return rnd_org();
    endcase
    org = pos - hot;
    if (org < -1024) org = -1024;
    if (org > 2047) org = 2047;
    return org;
  endfunction

  // Offer one mask byte request, maybe after an idle burst; hold it until
  // taken, then note it in the tracker.
  task automatic send_byte(input logic [7:0] b, input logic start, input int ox,
                           input int oy);
    in_item_t req;
    if (!quiet && !burst && $urandom_range(5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req.mask_byte = b;
    req.mask_start = start;
    req.origin_x = ox[ORG_W-1:0];
    req.origin_y = oy[ORG_W-1:0];
    in_if.valid <= 1'b1;
    in_if.mask_byte <= req.mask_byte;
    in_if.mask_start <= req.mask_start;
    in_if.origin_x <= req.origin_x;
    in_if.origin_y <= req.origin_y;
    do @(posedge clk); while (!in_if.ready);
    spans.note_request(req);
    req_total++;
  endtask

  // Send header and rows. Tidy rows have runs that add up to the width; a
  // wide row uses a block count of 256 (sent as zero) with tiny runs; a
  // nonzero cut stops the mask at a run byte once that many bytes are sent.
  task automatic send_mask(input int ox, input int oy, input int w, input int h,
                           input int hx, input int hy, input bit tidy,
                           input bit wide_row, input int cut);
    int first, n, left, run;
    first = req_total;
    send_byte(8'(w), 1'b1, ox, oy);
    send_byte(8'(h), 1'b0, rnd_org(), rnd_org());
    send_byte(8'(hx), 1'b0, rnd_org(), rnd_org());
    send_byte(8'(hy), 1'b0, rnd_org(), rnd_org());
    for (int r = 0; r < h; r++) begin
      n = wide_row ? 256 : int'($urandom_range(1, 7));
      send_byte(8'(n), 1'b0, rnd_org(), rnd_org());
      left = w;
      for (int k = 0; k < n; k++) begin
        if (cut > 0 && req_total - first >= cut) return;
        if (wide_row) begin
          run = $urandom_range(1);
        end else if (!tidy) begin
          run = $urandom_range(255);
        end else if (k == n - 1) begin
          run = left;
        end else begin
          run = $urandom_range(left);
          left -= run;
        end
        send_byte(8'(run), 1'b0, rnd_org(), rnd_org());
      end
    end
  endtask

  task automatic random_mask();
    int w, h, hx, hy, cut;
    case ($urandom_range(7))
      0:       w = 0;
      1, 2:    w = $urandom_range(255);
      default: w = $urandom_range(1, 40);
    endcase
    h = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(1, 5));
    hx = ($urandom_range(3) == 0) ? int'($urandom_range(255)) : int'($urandom_range(8));
    hy = ($urandom_range(3) == 0) ? int'($urandom_range(255)) : int'($urandom_range(8));
    cut = ($urandom_range(7) == 0) ? int'($urandom_range(2, 12)) : 0;
    send_mask(place(spans.clip_l, spans.clip_r, w, hx), place(spans.clip_t, spans.clip_b, h, hy),
              w, h, hx, hy, $urandom_range(3) != 0, 1'b0, cut);
    // Drop in a stray byte now and then; it lands idle or inside a cut mask.
    if (!burst && $urandom_range(9) == 0) begin
      send_byte(8'($urandom), 1'b0, rnd_org(), rnd_org());
      noise_reqs++;
    end
  endtask

  task automatic run_masks(input int goal);
    int start;
    start = req_total - noise_reqs;
    while (req_total - noise_reqs - start < goal) random_mask();
  endtask

  // Hold until every predicted result has been taken.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (spans.pending() != 0) @(posedge clk);
  endtask

  // Setup then access cycle; the register takes the value at the end of the access cycle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    spans.set_reg(idx, value);
  endtask

  task automatic set_window(input int l, input int t, input int r, input int b,
                            input int p);
    drain();
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_BOTTOM, b);
    write_reg(REG_FRAME_PITCH, p);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    windows++;
  endtask

  task automatic random_window();
    int l, t;
    l = $urandom_range(1023);
    t = $urandom_range(1023);
    set_window(l, t, l + int'($urandom_range(1024)), t + int'($urandom_range(1024)),
               $urandom_range(1, 2048));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    spans = new();
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.mask_byte <= '0;
    in_if.mask_start <= 1'b0;
    in_if.origin_x <= '0;
    in_if.origin_y <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset window.
    // A byte with no mask in progress gives an all-zero result.
    send_byte(8'hFF, 1'b0, 2047, -1024);
    // Far left of the window with every header byte at its maximum: rejected.
    send_byte(8'd255, 1'b1, -1024, 2047);
    send_byte(8'd255, 1'b0, 0, 0);
    send_byte(8'd255, 1'b0, 0, 0);
    send_byte(8'd255, 1'b0, 0, 0);
    // Zero height with a negative origin row: ends on the last header byte.
    send_byte(8'd0, 1'b1, 0, -1024);
    send_byte(8'd0, 1'b0, 0, 0);
    send_byte(8'd0, 1'b0, 0, 0);
    send_byte(8'd0, 1'b0, 0, 0);
    // Clipped on the left: an odd count ending on a skip with an empty copy,
    // then an even count ending on a copy.
    send_byte(8'd20, 1'b1, -10, -5);
    send_byte(8'd2, 1'b0, 0, 0);
    send_byte(8'd0, 1'b0, 0, 0);
    send_byte(8'd0, 1'b0, 0, 0);
    send_byte(8'd3, 1'b0, 0, 0);
    send_byte(8'd2, 1'b0, 0, 0);
    send_byte(8'd0, 1'b0, 0, 0);
    send_byte(8'd18, 1'b0, 0, 0);
    send_byte(8'd2, 1'b0, 0, 0);
    send_byte(8'd5, 1'b0, 0, 0);
    send_byte(8'd15, 1'b0, 0, 0);
    // Restart in the middle of a header, then a small mask fully inside.
    send_byte(8'd8, 1'b1, 100, 100);
    send_byte(8'd1, 1'b0, 0, 0);
    send_byte(8'd4, 1'b1, 600, 470);
    send_byte(8'd1, 1'b0, 0, 0);
    send_byte(8'd3, 1'b0, 0, 0);
    send_byte(8'd3, 1'b0, 0, 0);
    send_byte(8'd2, 1'b0, 0, 0);
    send_byte(8'd0, 1'b0, 0, 0);
    send_byte(8'd255, 1'b0, 0, 0);

    run_masks(60);

    set_window(100, 50, 300, 200, 320);
    run_masks(150);

    // Widest window and a pitch of 2048; one row with a block count of 256.
    set_window(0, 0, 2047, 2047, 2048);
    send_mask(10, 10, 200, 1, 0, 0, 1'b0, 1'b1, 0);
    run_masks(60);

    // Single pixel window at the far corner, pitch of one.
    set_window(2047, 2047, 2047, 2047, 1);
    run_masks(80);

    // Inverted window: same compares apply.
    set_window(500, 400, 100, 50, 1000);
    run_masks(80);

    // Long hold-off on the result side while requests keep coming.
    random_window();
    hold_req = 1'b1;
    wait (!hold_req);
    burst = 1'b1;
    run_masks(60);
    burst = 1'b0;
    run_masks(40);

    // Pause the sender until everything is out, then carry on.
    random_window();
    run_masks(50);
    drain();
    run_masks(50);

    // Last stretch with no idling anywhere.
    random_window();
    quiet = 1'b1;
    run_masks(100);

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d mask byte requests (%0d stray) over %0d clip settings.",
             req_total, noise_reqs, windows);
    $display("Saw %0d visible spans, %0d finished masks, %0d rejected masks.",
             spans.spans_seen, spans.masks_done, spans.masks_rejected);
    if (spans.mismatches == 0 && spans.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
